// ===== src/gjsa_pkg.sv =====
// shared widths, register indexes, reset values and bundle types of the servo aimer
// no dependencies; every other file of the block imports this package
package gjsa_pkg;

	localparam int SAMPLE_W   = 10;
	localparam int DUTY_W     = 8;
	localparam int DT_W       = 8;
	localparam int LIMIT_W    = 23;
	localparam int ANG_W      = 24;
	localparam int RATE_W     = 11;
	localparam int DELTA_W    = 20;
	localparam int CNT_W      = 11;
	localparam int NUM_W      = 32;
	localparam int DEN_W      = 24;
	localparam int STEP_W     = $clog2(NUM_W);
	localparam int IN_W       = 56;
	localparam int OUT_W      = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_ZERO = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_YAW_ZERO   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LIM  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_LOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_HIGH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_YAW_LOW    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_YAW_HIGH   = 3'd7;

	localparam logic [SAMPLE_W-1:0] RST_ZERO_OFFSET = 10'd512;
	localparam logic [SAMPLE_W-1:0] RST_DEADBAND    = 10'd4;
	localparam logic [LIMIT_W-1:0]  RST_ANGLE_LIMIT = 23'd1000000;
	localparam logic [DUTY_W-1:0]   RST_PWM_LOW     = 8'd16;
	localparam logic [DUTY_W-1:0]   RST_PWM_HIGH    = 8'd32;

	// first member sits in the top bits of a packed struct
	typedef struct packed {
		logic [DT_W-1:0]     elapsed_ms;
		logic                toggle_pressed;
		logic                trigger_level;
		logic [SAMPLE_W-1:0] gyro_yaw_sample;
		logic [SAMPLE_W-1:0] gyro_pitch_sample;
		logic [SAMPLE_W-1:0] joy_y_sample;
		logic [SAMPLE_W-1:0] joy_x_sample;
	} in_t;

	typedef struct packed {
		logic              gyro_mode;
		logic              trigger_pressed;
		logic [DUTY_W-1:0] yaw_duty;
		logic [DUTY_W-1:0] pitch_duty;
	} result_t;

	typedef struct packed {
		logic load;
		logic mul_rate;
		logic integ;
		logic prep;
		logic mul_map;
		logic div_start;
		logic store;
		logic ch;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} status_t;

endpackage

// ===== src/gyro_joystick_servo_aimer_core.sv =====
// top level of the gyro and joystick servo aimer: ports, output register, glue
// depends on gjsa_pkg, gjsa_ctrl and gjsa_datapath
//
// channel | direction | transaction carries
// s_*     | in        | one control tick: joystick, gyro, buttons, elapsed ms
// m_*     | out       | pitch and yaw duties, trigger servo, mode
// cfg_*   | in        | one register write, index and data
//
// one tick is worked at a time, and the next is taken only after its result is
// registered; the shared restoring divider runs 32 steps once for pitch and once
// for yaw
// reset is asynchronous and active low; it restores register defaults and state
// the next tick is taken while a finished result still waits on m_*
// a stalled m_* holds its transaction; configuration is always ready
module gyro_joystick_servo_aimer_core import gjsa_pkg::*; #(
	parameter int ADC_FULL_SCALE   = 1023,
	parameter int PRESS_AFTER_MS   = 700,
	parameter int RELEASE_AFTER_MS = 350
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// joy_x_sample[9:0], joy_y_sample[19:10], gyro_pitch_sample[29:20],
	// gyro_yaw_sample[39:30], trigger_level[40], toggle_pressed[41],
	// elapsed_ms[49:42], zero fill[55:50]
	input  logic [IN_W-1:0]       s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// pitch_duty[7:0], yaw_duty[15:8], trigger_pressed[16], gyro_mode[17],
	// zero fill[23:18]
	output logic [OUT_W-1:0]      m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int RES_W = $bits(result_t);

	in_t              in_item;
	result_t          result;
	cmd_t             cmd;
	status_t          status;
	logic             emit;
	logic             out_free;
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	// the packed fields line up with the tdata layout, fill bits dropped
	assign in_item = in_t'(s_tdata[$bits(in_t)-1:0]);

	assign cfg_ready = 1'b1;

	// result slot frees up in the same cycle the sink takes it
	assign out_free = !m_tvalid_q || m_tready;

	gjsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.status   (status),
		.in_ready (s_tready),
		.emit     (emit),
		.cmd      (cmd)
	);

	gjsa_datapath #(
		.ADC_FULL_SCALE   (ADC_FULL_SCALE),
		.PRESS_AFTER_MS   (PRESS_AFTER_MS),
		.RELEASE_AFTER_MS (RELEASE_AFTER_MS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

	// output register, parts the datapath from the sink
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			m_tdata_q <= {{(OUT_W-RES_W){1'b0}}, result};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== src/gjsa_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
// depends on gjsa_pkg for operand widths
module gjsa_div import gjsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic              done,
	output logic [DUTY_W-1:0] quot
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [NUM_W-1:0]  sh_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              ge;

	assign trial = {rem_q, sh_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// dividend shifts out at the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			sh_q  <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			sh_q  <= {sh_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = sh_q[DUTY_W-1:0];

endmodule

// ===== src/gjsa_datapath.sv =====
// datapath: configuration registers, angle integrators, trigger pulse train, line maps
// depends on gjsa_pkg and gjsa_div
module gjsa_datapath import gjsa_pkg::*; #(
	parameter int ADC_FULL_SCALE   = 1023,
	parameter int PRESS_AFTER_MS   = 700,
	parameter int RELEASE_AFTER_MS = 350
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  in_t                   in_item,
	input  cmd_t                  cmd,
	output status_t               status,
	output result_t               result
);

	logic [SAMPLE_W-1:0] pitch_zero_q, yaw_zero_q, deadband_q;
	logic [LIMIT_W-1:0]  angle_limit_q;
	logic [DUTY_W-1:0]   pitch_low_q, pitch_high_q, yaw_low_q, yaw_high_q;

	logic                      mode_q;
	logic signed [ANG_W-1:0]   pitch_angle_q, yaw_angle_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      trig_held_q;

	logic signed [RATE_W-1:0]  rate_p_q, rate_y_q;
	logic                      gate_p_q, gate_y_q;
	logic [DT_W-1:0]           dt_q;
	logic [SAMPLE_W-1:0]       joy_x_q, joy_y_q;
	logic signed [DELTA_W-1:0] delta_p_q, delta_y_q;

	logic [DEN_W-1:0]  n_q, den_q;
	logic [DUTY_W-1:0] absd_q, lo_q, hi_q;
	logic              neg_q;
	logic [NUM_W-1:0]  num_q;
	logic [DUTY_W-1:0] pitch_duty_q, yaw_duty_q;

	logic [LIMIT_W-1:0]        lim;
	logic signed [RATE_W-1:0]  rate_p, rate_y, mag_p, mag_y;
	logic signed [DELTA_W-1:0] prod_p, prod_y;
	logic signed [ANG_W:0]     n_gyro;
	logic [DUTY_W:0]           diff;
	logic [DUTY_W-1:0]         sel_lo, sel_hi, quot, qs, v;
	logic [SAMPLE_W-1:0]       sel_joy;
	logic signed [ANG_W-1:0]   sel_angle;
	logic [CNT_W:0]            cnt_sum;
	logic                      div_done;

	function automatic logic signed [ANG_W-1:0] clamp_angle(
		input logic signed [ANG_W-1:0]   angle,
		input logic signed [DELTA_W-1:0] delta,
		input logic [LIMIT_W-1:0]        limit
	);
		logic signed [ANG_W:0] sum;
		logic signed [ANG_W:0] bound;
		logic signed [ANG_W:0] r;
		sum   = {angle[ANG_W-1], angle} + {{(ANG_W+1-DELTA_W){delta[DELTA_W-1]}}, delta};
		bound = {2'b00, limit};
		if (sum > bound)
			r = bound;
		else if (sum < -bound)
			r = -bound;
		else
			r = sum;
		return r[ANG_W-1:0];
	endfunction

	// a zero limit acts as one
	assign lim = (angle_limit_q == '0) ? LIMIT_W'(1) : angle_limit_q;

	assign rate_p = $signed({1'b0, in_item.gyro_pitch_sample}) - $signed({1'b0, pitch_zero_q});
	assign rate_y = $signed({1'b0, in_item.gyro_yaw_sample}) - $signed({1'b0, yaw_zero_q});
	assign mag_p  = rate_p[RATE_W-1] ? -rate_p : rate_p;
	assign mag_y  = rate_y[RATE_W-1] ? -rate_y : rate_y;

	// signed rate times elapsed time, full width
	assign prod_p = rate_p_q * $signed({1'b0, dt_q});
	assign prod_y = rate_y_q * $signed({1'b0, dt_q});

	assign sel_lo    = cmd.ch ? yaw_low_q  : pitch_low_q;
	assign sel_hi    = cmd.ch ? yaw_high_q : pitch_high_q;
	assign sel_joy   = cmd.ch ? joy_x_q    : joy_y_q;
	assign sel_angle = cmd.ch ? yaw_angle_q : pitch_angle_q;
	assign n_gyro    = {sel_angle[ANG_W-1], sel_angle} + {2'b00, lim};
	assign diff      = {1'b0, sel_hi} - {1'b0, sel_lo};

	assign qs = neg_q ? (~quot + 1'b1) : quot;
	assign v  = lo_q + qs;

	// counter steps by this tick's elapsed time
	assign cnt_sum = {1'b0, cnt_q} + (CNT_W+1)'(in_item.elapsed_ms);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_zero_q  <= RST_ZERO_OFFSET;
			yaw_zero_q    <= RST_ZERO_OFFSET;
			deadband_q    <= RST_DEADBAND;
			angle_limit_q <= RST_ANGLE_LIMIT;
			pitch_low_q   <= RST_PWM_LOW;
			pitch_high_q  <= RST_PWM_HIGH;
			yaw_low_q     <= RST_PWM_LOW;
			yaw_high_q    <= RST_PWM_HIGH;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PITCH_ZERO: pitch_zero_q  <= cfg_data[SAMPLE_W-1:0];
				CFG_YAW_ZERO:   yaw_zero_q    <= cfg_data[SAMPLE_W-1:0];
				CFG_DEADBAND:   deadband_q    <= cfg_data[SAMPLE_W-1:0];
				CFG_ANGLE_LIM:  angle_limit_q <= cfg_data[LIMIT_W-1:0];
				CFG_PITCH_LOW:  pitch_low_q   <= cfg_data[DUTY_W-1:0];
				CFG_PITCH_HIGH: pitch_high_q  <= cfg_data[DUTY_W-1:0];
				CFG_YAW_LOW:    yaw_low_q     <= cfg_data[DUTY_W-1:0];
				CFG_YAW_HIGH:   yaw_high_q    <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	// mode, angles and the pulse train
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= 1'b0;
			pitch_angle_q <= '0;
			yaw_angle_q   <= '0;
			cnt_q         <= '0;
			trig_held_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				mode_q <= mode_q ^ in_item.toggle_pressed;
				if (!in_item.trigger_level) begin
					if (cnt_q > CNT_W'(PRESS_AFTER_MS)) begin
						trig_held_q <= 1'b1;
						cnt_q       <= '0;
					end else begin
						if (cnt_q > CNT_W'(RELEASE_AFTER_MS))
							trig_held_q <= 1'b0;
						cnt_q <= cnt_sum[CNT_W] ? CNT_MAX : cnt_sum[CNT_W-1:0];
					end
				end else begin
					cnt_q       <= '0;
					trig_held_q <= 1'b0;
				end
			end
			if (cmd.integ) begin
				pitch_angle_q <= clamp_angle(pitch_angle_q, delta_p_q, lim);
				yaw_angle_q   <= clamp_angle(yaw_angle_q, delta_y_q, lim);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rate_p_q <= rate_p;
			rate_y_q <= rate_y;
			gate_p_q <= mag_p > $signed({1'b0, deadband_q});
			gate_y_q <= mag_y > $signed({1'b0, deadband_q});
			dt_q     <= in_item.elapsed_ms;
			joy_x_q  <= in_item.joy_x_sample;
			joy_y_q  <= in_item.joy_y_sample;
		end
		if (cmd.mul_rate) begin
			delta_p_q <= gate_p_q ? prod_p : '0;
			delta_y_q <= gate_y_q ? prod_y : '0;
		end
		if (cmd.prep) begin
			if (mode_q) begin
				n_q   <= n_gyro[DEN_W-1:0];
				den_q <= {lim, 1'b0};
			end else begin
				n_q   <= DEN_W'(sel_joy);
				den_q <= DEN_W'(ADC_FULL_SCALE);
			end
			neg_q  <= diff[DUTY_W];
			absd_q <= diff[DUTY_W] ? (~diff[DUTY_W-1:0] + 1'b1) : diff[DUTY_W-1:0];
			lo_q   <= sel_lo;
			hi_q   <= sel_hi;
		end
		if (cmd.mul_map)
			num_q <= NUM_W'(n_q * absd_q);
		if (cmd.store) begin
			if (!cmd.ch)
				pitch_duty_q <= v;
			else if (mode_q)
				yaw_duty_q <= v;
			else
				yaw_duty_q <= hi_q + lo_q - v;
		end
	end

	gjsa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quot   (quot)
	);

	assign status.div_done = div_done;

	assign result.pitch_duty      = pitch_duty_q;
	assign result.yaw_duty        = yaw_duty_q;
	assign result.trigger_pressed = trig_held_q;
	assign result.gyro_mode       = mode_q;

endmodule

// ===== src/gjsa_ctrl.sv =====
// controller: sequences load, integration and the two divider passes of one tick
// depends on gjsa_pkg for the command and status bundles
module gjsa_ctrl import gjsa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    out_free,
	input  status_t status,
	output logic    in_ready,
	output logic    emit,
	output cmd_t    cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_MULR   = 4'd1;
	localparam logic [3:0] ST_INTEG  = 4'd2;
	localparam logic [3:0] ST_PREP   = 4'd3;
	localparam logic [3:0] ST_MULM   = 4'd4;
	localparam logic [3:0] ST_DSTART = 4'd5;
	localparam logic [3:0] ST_DWAIT  = 4'd6;
	localparam logic [3:0] ST_STORE  = 4'd7;
	localparam logic [3:0] ST_OUT    = 4'd8;

	logic [3:0] state_q, state_d;
	logic       ch_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.ch   = ch_q;
		in_ready = 1'b0;
		emit     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MULR;
				end
			end
			ST_MULR: begin
				cmd.mul_rate = 1'b1;
				state_d      = ST_INTEG;
			end
			ST_INTEG: begin
				cmd.integ = 1'b1;
				state_d   = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_MULM;
			end
			ST_MULM: begin
				cmd.mul_map = 1'b1;
				state_d     = ST_DSTART;
			end
			ST_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (status.div_done)
					state_d = ST_STORE;
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				state_d   = ch_q ? ST_OUT : ST_PREP;
			end
			ST_OUT: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.store)
				ch_q <= ~ch_q;
		end
	end

endmodule

// ===== src/gjsa_checker.sv =====
// port-level checks of the servo aimer top level, attached by bind
// depends on gjsa_pkg and gyro_joystick_servo_aimer_core
module gjsa_checker import gjsa_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	localparam int RES_W = $bits(result_t);

	// a stalled result keeps its transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one tick at a time: busy right after an accepted tick
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after acceptance");

	// the input side only goes busy because a tick was taken
	a_ready_falls_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid))
		else $error("input ready dropped without a transaction");

	// fill bits of the result stay zero
	a_out_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_W-1:RES_W] == '0)
		else $error("nonzero fill bits in result");

endmodule

bind gyro_joystick_servo_aimer_core gjsa_checker u_gjsa_checker (.*);
